// ----- rtl/dad_pkg.sv -----
// Shared types, constants and a helper function for the date advance block.
`timescale 1ns / 1ps

package dad_pkg;

  // Field widths of the request and result payloads.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  // Default width of the day count.
  localparam int DAY_COUNT_BITS_DEF = 16;

  // Calendar constants.
  localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] APRIL     = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] JUNE      = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] SEPTEMBER = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] NOVEMBER  = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);

  localparam logic [DAY_W-1:0] LEN_FEB      = DAY_W'(28);
  localparam logic [DAY_W-1:0] LEN_FEB_LEAP = DAY_W'(29);
  localparam logic [DAY_W-1:0] LEN_SHORT    = DAY_W'(30);
  localparam logic [DAY_W-1:0] LEN_LONG     = DAY_W'(31);

  localparam int CENTURY    = 100;
  localparam int LEAP_CYCLE = 400;

  // Year mod 400 is found by restoring subtraction of 400 shifted left
  // by REDUCE_STEPS-1 down to 0; 400 << 5 = 12800 covers a 14-bit year.
  localparam int REDUCE_STEPS = 6;
  localparam int STEP_W       = $clog2(REDUCE_STEPS);

  localparam logic [YEAR_W-1:0] YEAR_MAX = {YEAR_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK,
    ST_OUT
  } dad_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              reduce;
    logic              walk;
    logic [STEP_W-1:0] shift;
  } dad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;
  } dad_sts_t;

  // Length of a month in days, given whether the year is a leap year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic            leap);
    logic [DAY_W-1:0] len;
    if (month == FEBRUARY) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB;
    end else if (month == APRIL || month == JUNE || month == SEPTEMBER ||
                 month == NOVEMBER) begin
      len = LEN_SHORT;
    end else begin
      len = LEN_LONG;
    end
    return len;
  endfunction

endpackage

// ----- rtl/dad_if.sv -----
// Valid/ready channel interfaces for the date advance requests and results.
`timescale 1ns / 1ps

interface dad_in_if #(
  parameter int DAY_COUNT_BITS = dad_pkg::DAY_COUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [dad_pkg::DAY_W-1:0]   start_day;
  logic [dad_pkg::MONTH_W-1:0] start_month;
  logic [dad_pkg::YEAR_W-1:0]  start_year;
  logic [DAY_COUNT_BITS-1:0]   days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

interface dad_out_if;
  logic                        valid;
  logic                        ready;
  logic [dad_pkg::DAY_W-1:0]   end_day;
  logic [dad_pkg::MONTH_W-1:0] end_month;
  logic [dad_pkg::YEAR_W-1:0]  end_year;

  modport source (output valid, end_day, end_month, end_year, input ready);
  modport sink   (input valid, end_day, end_month, end_year, output ready);
endinterface

// ----- rtl/dad_datapath.sv -----
// Datapath of the date advance block: running day, month, year and year mod 400.
`timescale 1ns / 1ps

module dad_datapath #(
  parameter int DAY_COUNT_BITS = dad_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  dad_pkg::dad_cmd_t           cmd,
  output dad_pkg::dad_sts_t           sts,
  input  logic [dad_pkg::DAY_W-1:0]   start_day,
  input  logic [dad_pkg::MONTH_W-1:0] start_month,
  input  logic [dad_pkg::YEAR_W-1:0]  start_year,
  input  logic [DAY_COUNT_BITS-1:0]   days_to_add,
  output logic [dad_pkg::DAY_W-1:0]   end_day,
  output logic [dad_pkg::MONTH_W-1:0] end_month,
  output logic [dad_pkg::YEAR_W-1:0]  end_year
);

  // One bit above the count holds start day plus count.
  localparam int DW = DAY_COUNT_BITS + 1;
  localparam int YW = dad_pkg::YEAR_W;

  logic [DW-1:0]                 day_r,   day_nxt;
  logic [dad_pkg::MONTH_W-1:0]   month_r, month_nxt;
  logic [YW-1:0]                 year_r,  year_nxt;
  logic [YW-1:0]                 rem_r,   rem_nxt;
  logic [dad_pkg::MONTH_W-1:0]   month_in;
  logic [YW-1:0]                 sub;
  logic                          leap;
  logic                          century;
  logic [dad_pkg::DAY_W-1:0]     len;

  // A month code of zero means January, anything past twelve means December.
  always_comb begin
    if (start_month == '0) begin
      month_in = dad_pkg::JANUARY;
    end else if (start_month > dad_pkg::DECEMBER) begin
      month_in = dad_pkg::DECEMBER;
    end else begin
      month_in = start_month;
    end
  end

  assign sub     = YW'(dad_pkg::LEAP_CYCLE) << cmd.shift;
  assign century = (rem_r == YW'(0)) || (rem_r == YW'(dad_pkg::CENTURY)) ||
                   (rem_r == YW'(2 * dad_pkg::CENTURY)) ||
                   (rem_r == YW'(3 * dad_pkg::CENTURY));
  assign leap    = ((year_r[1:0] == 2'b00) && !century) || (rem_r == YW'(0));
  assign len     = dad_pkg::month_len(month_r, leap);
  assign sts.fits = (day_r <= DW'(len));

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rem_nxt   = rem_r;
    if (cmd.load) begin
      day_nxt   = DW'(start_day) + DW'(days_to_add);
      month_nxt = month_in;
      year_nxt  = start_year;
      rem_nxt   = start_year;
    end else if (cmd.reduce) begin
      if (rem_r >= sub) begin
        rem_nxt = rem_r - sub;
      end
    end else if (cmd.walk) begin
      day_nxt = day_r - DW'(len);
      if (month_r == dad_pkg::DECEMBER) begin
        month_nxt = dad_pkg::JANUARY;
        year_nxt  = year_r + YW'(1);
        // The year counter wraps to zero, which is a multiple of 400.
        if (year_r == dad_pkg::YEAR_MAX ||
            rem_r == YW'(dad_pkg::LEAP_CYCLE - 1)) begin
          rem_nxt = '0;
        end else begin
          rem_nxt = rem_r + YW'(1);
        end
      end else begin
        month_nxt = month_r + dad_pkg::MONTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    rem_r   <= rem_nxt;
  end

  assign end_day   = day_r[dad_pkg::DAY_W-1:0];
  assign end_month = month_r;
  assign end_year  = year_r;

endmodule

// ----- rtl/dad_ctrl.sv -----
// Controller state machine of the date advance block.
`timescale 1ns / 1ps

module dad_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dad_pkg::dad_cmd_t    cmd,
  input  dad_pkg::dad_sts_t    sts,
  output dad_pkg::dad_state_t  state
);

  dad_pkg::dad_state_t                state_r, state_nxt;
  logic [dad_pkg::STEP_W-1:0]         step_r,  step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dad_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.shift  = step_r;
    case (state_r)
      dad_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = dad_pkg::STEP_W'(dad_pkg::REDUCE_STEPS - 1);
          state_nxt = dad_pkg::ST_REDUCE;
        end
      end
      dad_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (step_r == '0) begin
          state_nxt = dad_pkg::ST_WALK;
        end else begin
          step_nxt = step_r - dad_pkg::STEP_W'(1);
        end
      end
      dad_pkg::ST_WALK: begin
        if (sts.fits) begin
          state_nxt = dad_pkg::ST_OUT;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      dad_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = dad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dad_pkg::ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ----- rtl/date_add_days_core.sv -----
// Top level of the date advance block: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// A request on in_req carries a start date (day, month, year) and a day
// count; the block answers with one result on out_res holding the date that
// many days later. Both channels use valid/ready; a transfer happens on a
// rising clock edge where both are high.
// The block handles one request at a time. After a request is taken, the
// start year is reduced modulo 400 for the leap rule, one compare and
// subtract per cycle. Then the month walk subtracts one month length per
// cycle until the day fits its month; this single subtract-and-step loop sets
// the throughput. The result is offered once the day fits, and the next
// request is taken in the idle state entered after the result leaves. The
// largest count, 65535 days, walks about 2150 months.
// If the receiver stalls, the result stays on out_res unchanged and no new
// request is taken until it is delivered.
// The synchronous active-low reset returns the controller to idle, ready for
// a request; a result in flight at reset is dropped.

module date_add_days_core #(
  parameter int DAY_COUNT_BITS = dad_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dad_in_if.sink       in_req,
  dad_out_if.source    out_res
);

  dad_pkg::dad_cmd_t   cmd;
  dad_pkg::dad_sts_t   sts;
  dad_pkg::dad_state_t state;

  // Sequencing: accept, reduce year, walk months, hold the result.
  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd),
    .sts       (sts),
    .state     (state)
  );

  // The running date lives in the datapath registers, which also drive the
  // result fields directly while the result is offered.
  dad_datapath #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .start_day   (in_req.start_day),
    .start_month (in_req.start_month),
    .start_year  (in_req.start_year),
    .days_to_add (in_req.days_to_add),
    .end_day     (out_res.end_day),
    .end_month   (out_res.end_month),
    .end_year    (out_res.end_year)
  );

  // A result is only offered once the day fits its month.
  a_out_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> sts.fits)
    else $error("result offered before the day fits its month");

  // The block never takes a request while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_req.ready && out_res.valid))
    else $error("request taken while a result is pending");

  // An accepted request always starts the year reduction.
  a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state == dad_pkg::ST_REDUCE))
    else $error("accepted request did not start year reduction");

  // The month stays a legal month once a request has been loaded.
  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state == dad_pkg::ST_WALK || state == dad_pkg::ST_OUT) |->
    (out_res.end_month >= dad_pkg::JANUARY && out_res.end_month <= dad_pkg::DECEMBER))
    else $error("month left the range January to December");

  // The result is held steady while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=>
    (out_res.valid && $stable(out_res.end_day) && $stable(out_res.end_month) &&
     $stable(out_res.end_year)))
    else $error("result changed while stalled");

endmodule
